// File: rtl/core/multiwidth_unsigned_divider_core_assert.svh
// Assertion macros used by the divider output buffer.
// Needs clk and rst_n in the scope of each use.
`ifndef MULTIWIDTH_UNSIGNED_DIVIDER_CORE_ASSERT_SVH
`define MULTIWIDTH_UNSIGNED_DIVIDER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mwd_pkg.sv
// Shared types, widths and width-code helpers for the divider core.
// No dependencies; used by every module of the core.
package mwd_pkg;

  localparam int DSOR_W    = 32;
  localparam int DEND_W    = 2 * DSOR_W;
  localparam int NUM_STEPS = DEND_W;

  // Operand width codes; bit 1 set selects the long width.
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_WORD = 2'd1;
  localparam logic [1:0] OP_LONG = 2'd2;
  localparam logic [1:0] OP_LONG_ALT = 2'd3;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic              valid;
    logic [1:0]        opcode;
    logic [DSOR_W-1:0] dsor;
    logic [DSOR_W-1:0] rem;
    logic [DEND_W-1:0] dq;
    logic              dz;
    logic              ov;
  } cell_t;

  // One finished result.
  typedef struct packed {
    logic [DSOR_W-1:0] quotient;
    logic [DSOR_W-1:0] remainder;
    logic              dz;
    logic              ov;
  } result_t;

  // Mask of the operand-width bits for a width code.
  function automatic logic [DSOR_W-1:0] width_mask(input logic [1:0] opcode);
    logic [DSOR_W-1:0] m;
    unique case (opcode)
      OP_BYTE:              m = {{(DSOR_W-8){1'b0}}, 8'hFF};
      OP_WORD:              m = {{(DSOR_W-16){1'b0}}, 16'hFFFF};
      OP_LONG, OP_LONG_ALT: m = {DSOR_W{1'b1}};
      default:              m = {DSOR_W{1'b1}};
    endcase
    return m;
  endfunction

endpackage

// File: rtl/core/mwd_cell.sv
// One restoring-division cell: a single compare-and-subtract step.
// Depends on mwd_pkg for cell_t and the operand widths.
module mwd_cell
  import mwd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t             cell_r;
  cell_t             cell_nxt;
  logic [DSOR_W:0]   trial;
  logic [DSOR_W:0]   diff;
  logic              take;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial    = {cell_i.rem, cell_i.dq[DEND_W-1]};
    diff     = trial - {1'b0, cell_i.dsor};
    take     = (trial >= {1'b0, cell_i.dsor});
    cell_nxt = cell_i;
    cell_nxt.rem = take ? diff[DSOR_W-1:0] : trial[DSOR_W-1:0];
    cell_nxt.dq  = {cell_i.dq[DEND_W-2:0], take};
  end

  // Stage register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (advance) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// File: rtl/core/mwd_out_buf.sv
// Two-entry output buffer that parts the divider pipeline from the result port.
// Depends on mwd_pkg for result_t and on the assertion macro header.
`include "multiwidth_unsigned_divider_core_assert.svh"

module mwd_out_buf
  import mwd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    head_r;
  result_t    tail_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = head_r;

  // Occupancy count.
  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entry storage: the head is always the oldest result.
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          head_r <= push_data;
        end else begin
          tail_r <= push_data;
        end
      end
      2'b01: begin
        head_r <= tail_r;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_r <= push_data;
        end else begin
          head_r <= tail_r;
          tail_r <= push_data;
        end
      end
      default: begin
        head_r <= head_r;
      end
    endcase
  end

  // A push into a full buffer must coincide with a transfer out.
  `MWD_ASSERT_NOW(a_no_overrun, push && full, pop, "output buffer overrun")
  // A stalled result stays presented and unchanged.
  `MWD_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready,
                   out_valid && $stable(out_data), "stalled result changed")
  // Draining the last entry without a push leaves the buffer empty.
  `MWD_ASSERT_NEXT(a_drain_empty, pop && !push && (count_r == 2'd1), !out_valid,
                   "buffer not empty after last transfer")

endmodule

// File: rtl/core/multiwidth_unsigned_divider_core.sv
// Top level of the pipelined unsigned divider for 8, 16 and 32 bit operands.
// Depends on mwd_pkg, mwd_cell and mwd_out_buf.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready   | opcode, dividend_high/low, divisor
//   out     | output    | out_valid / out_ready | quotient, remainder, flags
//
// One transfer in and one out per cycle while out_ready stays high. A result is
// loaded at its input transfer into the first of the 64 single-bit restoring
// division cells, passes down the chain, then enters the output buffer register.
// Reset clears the valid flags of the cells and the buffer occupancy only.
// A full output buffer that is not being drained freezes the whole cell chain
// and drops in_ready; two results wait there before the input side stalls.
module multiwidth_unsigned_divider_core
  import mwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_dividend_high,
  input  logic [31:0] in_dividend_low,
  input  logic [31:0] in_divisor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_quotient,
  output logic [31:0] out_remainder,
  output logic        out_divide_by_zero,
  output logic        out_quotient_overflow
);

  cell_t             chain [NUM_STEPS+1];
  cell_t             feed;
  logic              advance;
  logic              buf_full;
  logic              push;
  result_t           push_data;
  result_t           out_data;
  logic [DSOR_W-1:0] in_mask;
  logic [DSOR_W-1:0] hi_m;
  logic [DSOR_W-1:0] lo_m;
  logic [DSOR_W-1:0] dsor_m;
  logic [DEND_W-1:0] dend;
  logic [DSOR_W-1:0] last_mask;

  // The chain moves whenever the buffer can take what leaves it.
  assign advance  = !buf_full || out_ready;
  assign in_ready = advance;

  // Cut operands to the width and form the double-width dividend.
  always_comb begin
    in_mask = width_mask(in_opcode);
    hi_m    = in_dividend_high & in_mask;
    lo_m    = in_dividend_low & in_mask;
    dsor_m  = in_divisor & in_mask;
    unique case (in_opcode)
      OP_BYTE:              dend = {{(DEND_W-16){1'b0}}, hi_m[7:0], lo_m[7:0]};
      OP_WORD:              dend = {{(DEND_W-32){1'b0}}, hi_m[15:0], lo_m[15:0]};
      OP_LONG, OP_LONG_ALT: dend = {hi_m, lo_m};
      default:              dend = {hi_m, lo_m};
    endcase
  end

  // Feed of the first cell; the quotient overflows when high >= a nonzero divisor.
  always_comb begin
    feed.valid  = in_valid;
    feed.opcode = in_opcode;
    feed.dsor   = dsor_m;
    feed.rem    = '0;
    feed.dq     = dend;
    feed.dz     = (dsor_m == '0);
    feed.ov     = (dsor_m != '0) && (hi_m >= dsor_m);
  end

  assign chain[0] = feed;

  // Row of division cells, one quotient bit per cell.
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
    mwd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .cell_i  (chain[i]),
      .cell_o  (chain[i+1])
    );
  end

  // Cut quotient and remainder to the width; a zero divisor gives zero results.
  always_comb begin
    last_mask           = width_mask(chain[NUM_STEPS].opcode);
    push                = chain[NUM_STEPS].valid && advance;
    push_data.dz        = chain[NUM_STEPS].dz;
    push_data.ov        = chain[NUM_STEPS].ov;
    if (chain[NUM_STEPS].dz) begin
      push_data.quotient  = '0;
      push_data.remainder = '0;
    end else begin
      push_data.quotient  = chain[NUM_STEPS].dq[DSOR_W-1:0] & last_mask;
      push_data.remainder = chain[NUM_STEPS].rem & last_mask;
    end
  end

  mwd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_quotient          = out_data.quotient;
  assign out_remainder         = out_data.remainder;
  assign out_divide_by_zero    = out_data.dz;
  assign out_quotient_overflow = out_data.ov;

endmodule

// File: verif/multiwidth_unsigned_divider_core_tb.sv
// Self-checking testbench for the pipelined multi-width unsigned divider.
// Depends on mwd_pkg and multiwidth_unsigned_divider_core; stands alone otherwise.
`timescale 1ns / 100ps

module multiwidth_unsigned_divider_core_tb;
  import mwd_pkg::*;

  localparam int RESET_CYCLES  = 3;
  localparam int PIPE_LATENCY  = 65;
  localparam int RANDOM_ITEMS  = 1230;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_REPORTS   = 50;

  // Expected outcome of one divide.
  typedef struct {
    logic [31:0] quotient;
    logic [31:0] remainder;
    logic        dz;
    logic        ov;
  } div_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_BYTE;
  logic [31:0] in_dividend_high = '0;
  logic [31:0] in_dividend_low = '0;
  logic [31:0] in_divisor = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_quotient;
  logic [31:0] out_remainder;
  logic        out_divide_by_zero;
  logic        out_quotient_overflow;

  div_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned divides_sent = 0;
  int unsigned results_seen = 0;
  int unsigned zero_divisors = 0;
  int unsigned overflows = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  multiwidth_unsigned_divider_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_dividend_high     (in_dividend_high),
    .in_dividend_low      (in_dividend_low),
    .in_divisor           (in_divisor),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_quotient         (out_quotient),
    .out_remainder        (out_remainder),
    .out_divide_by_zero   (out_divide_by_zero),
    .out_quotient_overflow(out_quotient_overflow)
  );

  always #4 clk = ~clk;

  // Operand width in bits; bit 1 of the code selects the long width.
  function automatic int unsigned operand_bits(input logic [1:0] op);
    int unsigned bits;
    case (op)
      OP_BYTE:              bits = 8;
      OP_WORD:              bits = 16;
      OP_LONG, OP_LONG_ALT: bits = 32;
      default:              bits = 32;
    endcase
    return bits;
  endfunction

  function automatic logic [31:0] operand_mask(input logic [1:0] op);
    logic [63:0] m;
    m = (64'd1 << operand_bits(op)) - 64'd1;
    return m[31:0];
  endfunction

  // Quotient, remainder and flags of one divide, worked out at 64 bits.
  function automatic div_result_t divide_expected(input logic [1:0] op,
                                                  input logic [31:0] hi,
                                                  input logic [31:0] lo,
                                                  input logic [31:0] dsor);
    int unsigned bits;
    logic [63:0] mask;
    logic [63:0] dend;
    logic [63:0] dsor_cut;
    logic [63:0] q;
    logic [63:0] r;
    div_result_t res;
    bits     = operand_bits(op);
    mask     = {32'd0, operand_mask(op)};
    dend     = (({32'd0, hi} & mask) << bits) | ({32'd0, lo} & mask);
    dsor_cut = {32'd0, dsor} & mask;
    res.quotient  = '0;
    res.remainder = '0;
    res.dz        = 1'b0;
    res.ov        = 1'b0;
    if (dsor_cut == 64'd0) begin
      res.dz = 1'b1;
    end else begin
      q = dend / dsor_cut;
      r = dend % dsor_cut;
      res.ov        = (q > mask);
      res.quotient  = q[31:0] & mask[31:0];
      res.remainder = r[31:0] & mask[31:0];
    end
    return res;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (error_count < MAX_REPORTS)
      $display("[%0t] mismatch on result %0d, %s: expected %h, got %h",
               $time, results_seen, what, want, got);
    error_count++;
  endtask

  // Drive one divide and hold it until the transfer completes.
  task automatic send_divide(input logic [1:0] op, input logic [31:0] hi,
                             input logic [31:0] lo, input logic [31:0] dsor);
    int unsigned gap;
    div_result_t res;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_dividend_high <= hi;
    in_dividend_low  <= lo;
    in_divisor       <= dsor;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = divide_expected(op, hi, lo, dsor);
    pending_results.push_back(res);
    divides_sent++;
    if (res.dz) zero_divisors++;
    if (res.ov) overflows++;
  endtask

  // Hold the input side until every outstanding result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_width_extremes();
    // Largest quotient that still fits, with junk in the unused upper bits.
    send_divide(OP_BYTE, 32'hFFFF_FFFE, 32'hA5A5_A5FF, 32'h1234_56FF);
    send_divide(OP_BYTE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_divide(OP_BYTE, 32'h0000_0000, 32'h0000_0005, 32'h0000_0007);
    send_divide(OP_WORD, 32'h5A5A_FFFE, 32'hFFFF_FFFF, 32'h0000_FFFF);
    send_divide(OP_WORD, 32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0001);
    send_divide(OP_LONG, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_divide(OP_LONG, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_divide(OP_LONG, 32'h0000_0000, 32'hDEAD_BEEF, 32'h0000_0001);
    send_divide(OP_LONG, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
  endtask

  task automatic test_zero_divisor();
    // Only the operand-width bits of the divisor decide a zero divisor.
    send_divide(OP_BYTE, 32'h0000_00FF, 32'h0000_00FF, 32'hFFFF_FF00);
    send_divide(OP_WORD, 32'h0000_1234, 32'h0000_5678, 32'hABCD_0000);
    send_divide(OP_LONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_divide(OP_LONG, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_quotient_overflow();
    // High half equal to or above the divisor gives a quotient too wide.
    send_divide(OP_BYTE, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_0001);
    send_divide(OP_BYTE, 32'h0000_0010, 32'h0000_0000, 32'h0000_0010);
    send_divide(OP_WORD, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    send_divide(OP_LONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_divide(OP_LONG, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
  endtask

  task automatic test_alt_width_code();
    // The unused width code behaves as the long width.
    send_divide(OP_LONG_ALT, 32'h1234_5678, 32'h9ABC_DEF0, 32'h8000_0000);
    send_divide(OP_LONG_ALT, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0003);
    send_divide(OP_LONG_ALT, 32'h0000_0001, 32'h0000_0002, 32'h0000_0000);
  endtask

  task automatic test_random(input int unsigned count);
    logic [1:0]  op;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] dsor;
    logic [31:0] mask;
    int unsigned kind;
    for (int unsigned n = 0; n < count; n++) begin
      // Change the idling pattern now and then, with some stretches of none.
      if (n % 150 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (n == count / 2) wait_drained();
      op   = 2'($urandom_range(OP_BYTE, OP_LONG_ALT));
      hi   = $urandom();
      lo   = $urandom();
      dsor = $urandom();
      mask = operand_mask(op);
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // Quotient that fits: keep the high half below the divisor.
        if ((dsor & mask) == '0) dsor = dsor | 32'd1;
        hi = (hi & ~mask) | ((hi & mask) % (dsor & mask));
      end else if (kind < 60) begin
        dsor = (dsor & ~mask) | $urandom_range(1, 3);
      end else if (kind < 65) begin
        dsor = dsor & ~mask;
      end else if (kind < 75) begin
        hi = hi & ~mask;
      end
      send_divide(op, hi, lo, dsor);
    end
  endtask

  // Receiver: random stalls of random length, except in steady stretches.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 30)
        stall_left <= pick_gap() + 1;
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin : check_results
    div_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, quotient", '0, out_quotient);
      end else begin
        want = pending_results.pop_front();
        if (out_quotient !== want.quotient)
          report_mismatch("quotient", want.quotient, out_quotient);
        if (out_remainder !== want.remainder)
          report_mismatch("remainder", want.remainder, out_remainder);
        if (out_divide_by_zero !== want.dz)
          report_mismatch("divide_by_zero", {31'd0, want.dz}, {31'd0, out_divide_by_zero});
        if (out_quotient_overflow !== want.ov)
          report_mismatch("quotient_overflow", {31'd0, want.ov},
                          {31'd0, out_quotient_overflow});
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_width_extremes();
    test_zero_divisor();
    wait_drained();
    test_quotient_overflow();
    test_alt_width_code();
    test_random(RANDOM_ITEMS);

    // Let the pipeline empty, then allow for any stray transfer.
    wait_drained();
    repeat (PIPE_LATENCY + 5) @(posedge clk);

    $display("Ran %0d divides over all width codes: %0d by zero, %0d with a too-wide quotient.",
             divides_sent, zero_divisors, overflows);
    $display("Checked %0d results with random gaps and stalls on both channels.",
             results_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/mwd_pkg.sv
rtl/core/mwd_cell.sv
rtl/core/mwd_out_buf.sv
rtl/core/multiwidth_unsigned_divider_core.sv
verif/multiwidth_unsigned_divider_core_tb.sv
